[rtl/core/pssc_pkg.sv]
// Shared types and constants for the per-stream sequence checker.
// No dependencies; used by pssc_update and per_stream_sequence_checker.
`timescale 1ns / 1ps

package pssc_pkg;

    localparam int STREAM_COUNT = 256;
    localparam int IDX_W = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;
    localparam int SID_W = 8;
    localparam int SID_VALUES = 2 ** SID_W;

    typedef enum logic [2:0] {
        ST_IN_ORDER   = 3'd0,
        ST_FIRST_SYNC = 3'd1,
        ST_GAP        = 3'd2,
        ST_MISORDER   = 3'd3,
        ST_READ       = 3'd4
    } status_t;

    typedef enum logic {
        ACT_PACKET = 1'b0,
        ACT_READ   = 1'b1
    } action_t;

    typedef struct packed {
        logic [0:0]       action;
        logic [SID_W-1:0] stream_id;
        logic [15:0]      packet_length;
        logic [31:0]      received_seq;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] expected_seq;
        logic [31:0] seen_seq;
        logic [31:0] packet_count;
        logic [31:0] byte_count;
        logic [31:0] dropped_count;
        logic [31:0] misorder_count;
    } out_item_t;

    // One stream's table entry
    typedef struct packed {
        logic [31:0] last_seq;
        logic [31:0] packets;
        logic [31:0] bytes;
        logic [31:0] drops;
        logic [31:0] misorders;
    } entry_t;

    typedef logic [IDX_W-1:0] idx_lut_t [SID_VALUES];

    // Stream id to table index, worked out at elaboration
    function automatic idx_lut_t build_idx_lut();
        idx_lut_t lut;
        for (int i = 0; i < SID_VALUES; i++)
        begin
            lut[i] = IDX_W'(i % STREAM_COUNT);
        end
        return lut;
    endfunction

    localparam idx_lut_t IDX_LUT = build_idx_lut();

endpackage

[rtl/core/per_stream_sequence_checker.sv]
// Top level of the per-stream sequence checker: stream table memory,
// sequencing FSM and output register. Depends on pssc_pkg, pssc_update.
`timescale 1ns / 1ps

//  channel | signals                         | payload
//  --------+---------------------------------+------------------------
//  input   | in_valid / in_ready             | in_data  (in_item_t)
//  output  | out_valid / out_ready           | out_data (out_item_t)
//
//  For each transaction the accept edge issues the synchronous table read;
//  the update state then writes the updated entry back and loads the
//  output register, once that register can take the result.
//  A stalled output holds the block in its update cycle until the held
//  result is taken; a new transaction is accepted while a result waits.
//  Reset clears a per-entry valid bit; an entry not yet written reads as
//  zero, so no clearing pass is needed after reset.

module per_stream_sequence_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pssc_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pssc_pkg::out_item_t out_data
);

    typedef enum logic {
        S_IDLE,
        S_CALC
    } state_t;

    state_t                          state_reg;
    logic                            out_valid_reg;
    pssc_pkg::out_item_t             out_reg;
    pssc_pkg::in_item_t              item_reg;
    logic [pssc_pkg::IDX_W-1:0]      idx_reg;
    logic                            hit_reg;
    logic [pssc_pkg::STREAM_COUNT-1:0] valid_reg;

    // stream table, one wide entry per stream
    pssc_pkg::entry_t table_mem [pssc_pkg::STREAM_COUNT];
    pssc_pkg::entry_t rd_data_reg;

    logic                       in_fire;
    logic                       wr_en;
    logic [pssc_pkg::IDX_W-1:0] rd_idx;
    pssc_pkg::entry_t           cur_entry;
    pssc_pkg::entry_t           nxt_entry;
    pssc_pkg::out_item_t        result;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign rd_idx    = pssc_pkg::IDX_LUT[in_data.stream_id];
    // write back once the output register can take the result
    assign wr_en     = (state_reg == S_CALC) && (!out_valid_reg || out_ready);
    assign cur_entry = hit_reg ? rd_data_reg : '0;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    pssc_update u_update
    (
        .item (item_reg),
        .cur  (cur_entry),
        .nxt  (nxt_entry),
        .res  (result)
    );

    // table memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[idx_reg] <= nxt_entry;
        end
        if (in_fire)
        begin
            rd_data_reg <= table_mem[rd_idx];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_data;
            idx_reg  <= rd_idx;
        end
        if (wr_en)
        begin
            out_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            // a fresh result replaces one taken on the same edge
            if (wr_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        hit_reg   <= valid_reg[rd_idx];
                        state_reg <= S_CALC;
                    end
                end
                S_CALC:
                begin
                    if (wr_en)
                    begin
                        valid_reg[idx_reg] <= 1'b1;
                        state_reg          <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // an accepted transaction always moves to the update state with the input held off
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_CALC) && !in_ready)
        else $error("accept not followed by update cycle");

    // a new result only ever comes out of a write-back
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(wr_en))
        else $error("result without table write-back");

    // a written entry is marked valid
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> valid_reg[$past(idx_reg)])
        else $error("written entry not marked valid");

    // the update never overwrites a result that has not been taken
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !out_valid_reg || out_ready)
        else $error("output overrun");

endmodule

[rtl/core/pssc_update.sv]
// Per-stream entry update: sequence classification and counter arithmetic.
// Depends on pssc_pkg.
`timescale 1ns / 1ps

module pssc_update
(
    input  pssc_pkg::in_item_t  item,
    input  pssc_pkg::entry_t    cur,
    output pssc_pkg::entry_t    nxt,
    output pssc_pkg::out_item_t res
);

    logic [31:0] expect_seq;
    logic [31:0] pkts_inc;
    logic [31:0] bytes_inc;

    assign expect_seq = cur.last_seq + 32'd1;
    assign pkts_inc   = cur.packets + 32'd1;
    assign bytes_inc  = cur.bytes + {16'd0, item.packet_length};

    always_comb
    begin
        nxt = cur;
        res.expected_seq = expect_seq;
        res.seen_seq     = item.received_seq;
        res.status       = pssc_pkg::ST_IN_ORDER;
        if (item.action == pssc_pkg::ACT_READ)
        begin
            // report then clear the whole entry
            res.status   = pssc_pkg::ST_READ;
            res.seen_seq = 32'd0;
            nxt          = '0;
        end
        else
        begin
            nxt.packets = pkts_inc;
            nxt.bytes   = bytes_inc;
            if (expect_seq == item.received_seq)
            begin
                res.status   = pssc_pkg::ST_IN_ORDER;
                nxt.last_seq = expect_seq;
            end
            else if (expect_seq == 32'd1)
            begin
                res.status   = pssc_pkg::ST_FIRST_SYNC;
                nxt.last_seq = item.received_seq;
            end
            else if (expect_seq < item.received_seq)
            begin
                res.status   = pssc_pkg::ST_GAP;
                nxt.drops    = cur.drops + (item.received_seq - expect_seq);
                nxt.last_seq = item.received_seq;
            end
            else
            begin
                res.status    = pssc_pkg::ST_MISORDER;
                nxt.misorders = cur.misorders + 32'd1;
                if (cur.drops != 32'd0)
                begin
                    nxt.drops = cur.drops - 32'd1;
                end
            end
        end
        // read reports pre-clear counts, packets report post-update counts
        if (item.action == pssc_pkg::ACT_READ)
        begin
            res.packet_count   = cur.packets;
            res.byte_count     = cur.bytes;
            res.dropped_count  = cur.drops;
            res.misorder_count = cur.misorders;
        end
        else
        begin
            res.packet_count   = nxt.packets;
            res.byte_count     = nxt.bytes;
            res.dropped_count  = nxt.drops;
            res.misorder_count = nxt.misorders;
        end
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for per_stream_sequence_checker: directed and random
// packet/read transactions scored against an in-bench copy of the stream table.
// Depends on pssc_pkg and the per_stream_sequence_checker RTL.

module testbench;
    import pssc_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int CHUNKS       = 5;     // random chunks per idling phase
    localparam int CHUNK_ITEMS  = 82;    // 3 phases x 5 x 82 = 1230 random transactions
    localparam int HOT_STREAMS  = 8;
    localparam int TAIL_CYCLES  = 16;    // tail wait before the verdict; plenty of margin
    localparam int TIMEOUT_NS   = 4_000_000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    per_stream_sequence_checker dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard stop in case the block hangs or loses a transaction.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the stream table, updated in acceptance order.
    // ------------------------------------------------------------------
    logic [31:0] shadow_last      [STREAM_COUNT];
    logic [31:0] shadow_packets   [STREAM_COUNT];
    logic [31:0] shadow_bytes     [STREAM_COUNT];
    logic [31:0] shadow_drops     [STREAM_COUNT];
    logic [31:0] shadow_misorders [STREAM_COUNT];

    in_item_t  pending_items    [$];   // filled by the stimulus block, drained by the driver
    out_item_t expected_reports [$];   // one per accepted transaction, oldest first

    int unsigned send_idle_pct = 16;
    int unsigned recv_idle_pct = 66;
    int unsigned error_count   = 0;

    // Stimulus-side guess of each stream's last sequence; only steers the
    // random mix toward in-order/gap/misorder, never used for checking.
    logic [31:0] stim_last [256];
    logic [7:0]  hot_ids   [HOT_STREAMS];

    // Sequence accounting for one transaction; returns the report the block
    // must produce and commits the table update.
    function automatic out_item_t update_stream_stats(in_item_t t);
        out_item_t   r;
        int unsigned idx;
        logic [31:0] next_seq;
        idx      = int'(t.stream_id) % STREAM_COUNT;
        next_seq = shadow_last[idx] + 32'd1;
        r              = '0;
        r.expected_seq = next_seq;
        if (t.action == ACT_READ)
        begin
            // Report the counters as they stand, then wipe the whole entry.
            r.status                = ST_READ;
            r.seen_seq              = '0;
            r.packet_count          = shadow_packets[idx];
            r.byte_count            = shadow_bytes[idx];
            r.dropped_count         = shadow_drops[idx];
            r.misorder_count        = shadow_misorders[idx];
            shadow_last[idx]        = '0;
            shadow_packets[idx]     = '0;
            shadow_bytes[idx]       = '0;
            shadow_drops[idx]       = '0;
            shadow_misorders[idx]   = '0;
        end
        else
        begin
            r.seen_seq          = t.received_seq;
            shadow_packets[idx] = shadow_packets[idx] + 32'd1;
            shadow_bytes[idx]   = shadow_bytes[idx] + 32'(t.packet_length);
            if (next_seq == t.received_seq)
            begin
                r.status         = ST_IN_ORDER;
                shadow_last[idx] = next_seq;
            end
            else if (next_seq == 32'd1)
            begin
                // Fresh or cleared stream: adopt whatever arrives.
                r.status         = ST_FIRST_SYNC;
                shadow_last[idx] = t.received_seq;
            end
            else if (next_seq < t.received_seq)
            begin
                // Plain unsigned compare, no wrap awareness; drops wrap mod 2^32.
                r.status          = ST_GAP;
                shadow_drops[idx] = shadow_drops[idx] + (t.received_seq - next_seq);
                shadow_last[idx]  = t.received_seq;
            end
            else
            begin
                // Late packet: it was counted as dropped earlier, so take one back,
                // but never below zero. Stored sequence is left alone.
                r.status              = ST_MISORDER;
                shadow_misorders[idx] = shadow_misorders[idx] + 32'd1;
                if (shadow_drops[idx] != 32'd0)
                    shadow_drops[idx] = shadow_drops[idx] - 32'd1;
            end
            r.packet_count   = shadow_packets[idx];
            r.byte_count     = shadow_bytes[idx];
            r.dropped_count  = shadow_drops[idx];
            r.misorder_count = shadow_misorders[idx];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t ns] %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
        error_count++;
    endtask

    task automatic check_report(input out_item_t got);
        out_item_t want;
        if (expected_reports.size() == 0)
        begin
            report_mismatch("result with no transaction outstanding", got.expected_seq, '0);
        end
        else
        begin
            want = expected_reports.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.expected_seq !== want.expected_seq)
                report_mismatch("expected_seq", got.expected_seq, want.expected_seq);
            if (got.seen_seq !== want.seen_seq)
                report_mismatch("seen_seq", got.seen_seq, want.seen_seq);
            if (got.packet_count !== want.packet_count)
                report_mismatch("packet_count", got.packet_count, want.packet_count);
            if (got.byte_count !== want.byte_count)
                report_mismatch("byte_count", got.byte_count, want.byte_count);
            if (got.dropped_count !== want.dropped_count)
                report_mismatch("dropped_count", got.dropped_count, want.dropped_count);
            if (got.misorder_count !== want.misorder_count)
                report_mismatch("misorder_count", got.misorder_count, want.misorder_count);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: one NBA per signal per edge. The accepted transaction is scored
    // at the edge it is taken; a new one is loaded only once the old is gone,
    // so valid never drops before acceptance and the payload holds steady.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_reports.push_back(update_stream_stats(in_data));
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes results when out_valid and out_ready were both high
    // before the edge; ready toggles at random per the current phase.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_report(out_data);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_packet(input logic [7:0] sid, input logic [15:0] len,
                               input logic [31:0] seq_no);
        in_item_t t;
        t.action        = ACT_PACKET;
        t.stream_id     = sid;
        t.packet_length = len;
        t.received_seq  = seq_no;
        pending_items.push_back(t);
    endtask

    // Length and sequence ride along on a read but must be ignored.
    task automatic push_read(input logic [7:0] sid, input logic [15:0] len,
                             input logic [31:0] seq_no);
        in_item_t t;
        t.action        = ACT_READ;
        t.stream_id     = sid;
        t.packet_length = len;
        t.received_seq  = seq_no;
        pending_items.push_back(t);
    endtask

    // Mostly well-formed flows on a few hot streams, with gaps, late packets,
    // wild values near the 32-bit edges, and occasional read-and-clear.
    task automatic push_random_item();
        logic [7:0]  sid;
        logic [15:0] len;
        logic [31:0] seq_no;
        int unsigned pick;
        sid = ($urandom_range(99) < 80) ? hot_ids[$urandom_range(HOT_STREAMS - 1)]
                                        : 8'($urandom);
        case ($urandom_range(9))
            0:       len = 16'h0000;
            1:       len = 16'hFFFF;
            default: len = 16'($urandom);
        endcase
        if ($urandom_range(99) < 7)
        begin
            push_read(sid, 16'($urandom), $urandom);
            stim_last[sid] = '0;
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                seq_no = stim_last[sid] + 32'd1;
            else if (pick < 70)
                seq_no = stim_last[sid] + 32'($urandom_range(20, 2));
            else if (pick < 85)
                seq_no = stim_last[sid] - 32'($urandom_range(10));
            else if (pick < 92)
                seq_no = $urandom;
            else if (pick < 96)
                seq_no = 32'hFFFF_FFFF - 32'($urandom_range(3));
            else
                seq_no = 32'($urandom_range(2));
            push_packet(sid, len, seq_no);
            // Late packets leave the stored sequence where it was.
            if (pick < 70 || pick >= 85)
                stim_last[sid] = seq_no;
        end
    endtask

    // Sender holds off until every outstanding result is back.
    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_reports.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < STREAM_COUNT; i++)
        begin
            shadow_last[i]      = '0;
            shadow_packets[i]   = '0;
            shadow_bytes[i]     = '0;
            shadow_drops[i]     = '0;
            shadow_misorders[i] = '0;
        end
        for (int i = 0; i < 256; i++)
            stim_last[i] = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: fresh read with junk in ignored fields
        push_read(8'd0, 16'hFFFF, 32'hFFFF_FFFF);
        // in order straight from reset (expected 1, got 1)
        push_packet(8'd1, 16'd0, 32'd1);
        // first sync, in order, gap of 8, late packet pulling drops back
        push_packet(8'd2, 16'd64, 32'd100);
        push_packet(8'd2, 16'hFFFF, 32'd101);
        push_packet(8'd2, 16'd1500, 32'd110);
        push_packet(8'd2, 16'd60, 32'd105);
        // late packet while dropped count is zero: stays zero
        push_packet(8'd4, 16'd100, 32'd10);
        push_packet(8'd4, 16'd100, 32'd11);
        push_packet(8'd4, 16'd100, 32'd3);
        // sequence wrap: sync at max, then 0 is in order, then resync
        push_packet(8'd3, 16'd1, 32'hFFFF_FFFF);
        push_packet(8'd3, 16'd1, 32'd0);
        push_packet(8'd3, 16'd1, 32'd7);
        // received zero on a fresh stream, twice
        push_packet(8'd5, 16'd0, 32'd0);
        push_packet(8'd5, 16'd0, 32'd0);
        // huge gap, then a second one that wraps the dropped count
        push_packet(8'd6, 16'd200, 32'd5);
        push_packet(8'd6, 16'd200, 32'hFFFF_FFFF);
        push_packet(8'd6, 16'd200, 32'hFFFF_FFFF);
        // top stream id, max length, late packet
        push_packet(8'hFF, 16'hFFFF, 32'd1);
        push_packet(8'hFF, 16'hFFFF, 32'd0);
        // reads with counts, read of a cleared entry, packet after clear
        push_read(8'd2, 16'd0, 32'd0);
        push_read(8'd2, 16'h5A5A, 32'h1234_5678);
        push_read(8'd6, 16'd0, 32'd0);
        push_read(8'hFF, 16'd0, 32'd0);
        push_packet(8'd2, 16'd0, 32'd1);
        wait_drained();

        // Random: three idling phases, each split into chunks with a full
        // drain in between so the sender pauses on an empty pipeline.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 16;
                    recv_idle_pct = 66;
                end
                1:
                begin
                    send_idle_pct = 66;
                    recv_idle_pct = 16;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int c = 0; c < CHUNKS; c++)
            begin
                for (int h = 0; h < HOT_STREAMS; h++)
                    hot_ids[h] = 8'($urandom);
                for (int n = 0; n < CHUNK_ITEMS; n++)
                    push_random_item();
                wait_drained();
            end
        end

        // Let any stray extra result show up before the verdict.
        repeat (TAIL_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/pssc_pkg.sv
rtl/core/pssc_update.sv
rtl/core/per_stream_sequence_checker.sv
tb/sv/testbench.sv
